### rtl/kdar_pkg.sv
package kdar_pkg;

    localparam int unsigned CNT_W  = 16;
    localparam int unsigned PINS_W = 8;

    localparam logic [CNT_W-1:0] DEBOUNCE_TICKS = CNT_W'(15);
    localparam logic [CNT_W-1:0] HOLD_TICKS     = CNT_W'(5);
    localparam logic [CNT_W-1:0] DEFAULT_PERIOD = CNT_W'(20);
    localparam logic [CNT_W-1:0] DEFAULT_DELAY  = CNT_W'(150);

    localparam logic [PINS_W-1:0] RST_PRESS_MASK    = PINS_W'(16);
    localparam logic [PINS_W-1:0] RST_OTHER_MASK    = PINS_W'(32);
    localparam logic [CNT_W-1:0]  RST_REPEAT_PERIOD = CNT_W'(100);
    localparam logic [CNT_W-1:0]  RST_REPEAT_DELAY  = CNT_W'(50);

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_HOLD     = 3'd2,
        PH_WAIT     = 3'd3,
        PH_REPEAT   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        REG_PRESS_MASK    = 2'd0,
        REG_OTHER_MASK    = 2'd1,
        REG_REPEAT_PERIOD = 2'd2,
        REG_REPEAT_DELAY  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [PINS_W-1:0] press_mask;
        logic [PINS_W-1:0] other_mask;
        logic [CNT_W-1:0]  repeat_period;
        logic [CNT_W-1:0]  repeat_delay;
    } t_cfg;

    typedef struct packed {
        logic   release_event;
        logic   repeat_event;
        t_phase phase;
    } t_result;

endpackage

### rtl/kdar_core.sv
module kdar_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [kdar_pkg::PINS_W-1:0] i_key_pins,
    input  logic                       i_tick,
    input  kdar_pkg::t_cfg             i_cfg,
    output kdar_pkg::t_result          o_result
);

    kdar_pkg::t_phase               r_phase, n_phase;
    logic [kdar_pkg::CNT_W-1:0]     r_countdown, n_countdown;

    logic [kdar_pkg::CNT_W-1:0]     cd_ticked;
    logic [kdar_pkg::CNT_W-1:0]     period;
    logic [kdar_pkg::CNT_W-1:0]     delay;
    logic                           other_en;
    logic                           other_hit;
    logic                           press;
    logic                           cd_zero;
    kdar_pkg::t_phase               phase_gated;
    logic                           rel;
    logic                           rep;

    always_comb begin
        cd_ticked = (i_tick && (r_countdown != '0)) ? r_countdown - 1'b1 : r_countdown;
        cd_zero   = (cd_ticked == '0);
        period    = (i_cfg.repeat_period == '0) ? kdar_pkg::DEFAULT_PERIOD
                                                : i_cfg.repeat_period;
        delay     = (i_cfg.repeat_delay == '0) ? kdar_pkg::DEFAULT_DELAY
                                               : i_cfg.repeat_delay;
        other_en  = |i_cfg.other_mask;
        other_hit = |(i_key_pins & i_cfg.other_mask);
        press     = ~|(i_key_pins & i_cfg.press_mask) && (!other_en || other_hit);
        // all other keys low: drop straight to idle
        phase_gated = (other_en && (r_phase != kdar_pkg::PH_IDLE) && !other_hit)
                    ? kdar_pkg::PH_IDLE : r_phase;
    end

    // next state
    always_comb begin
        n_phase     = phase_gated;
        n_countdown = cd_ticked;
        priority if (press && phase_gated == kdar_pkg::PH_IDLE) begin
            n_phase     = kdar_pkg::PH_DEBOUNCE;
            n_countdown = kdar_pkg::DEBOUNCE_TICKS;
        end else if (phase_gated == kdar_pkg::PH_IDLE) begin
            n_phase = kdar_pkg::PH_IDLE;
        end else if (press && phase_gated == kdar_pkg::PH_DEBOUNCE && cd_zero) begin
            n_phase     = kdar_pkg::PH_HOLD;
            n_countdown = kdar_pkg::HOLD_TICKS;
        end else if (!press && (phase_gated == kdar_pkg::PH_HOLD ||
                                phase_gated == kdar_pkg::PH_WAIT)) begin
            n_phase = kdar_pkg::PH_IDLE;
        end else if (press && phase_gated == kdar_pkg::PH_HOLD && cd_zero) begin
            n_phase     = kdar_pkg::PH_WAIT;
            n_countdown = delay;
        end else if (press && phase_gated == kdar_pkg::PH_WAIT && cd_zero) begin
            n_phase = kdar_pkg::PH_REPEAT;
        end else if (press && phase_gated == kdar_pkg::PH_REPEAT && cd_zero) begin
            n_countdown = period;
        end else if (!press && phase_gated == kdar_pkg::PH_REPEAT) begin
            n_phase = kdar_pkg::PH_IDLE;
        end else begin
            n_phase = phase_gated;
        end
    end

    // outputs
    always_comb begin
        rel = !press && (phase_gated == kdar_pkg::PH_HOLD ||
                         phase_gated == kdar_pkg::PH_WAIT);
        rep = press && (phase_gated == kdar_pkg::PH_REPEAT) && cd_zero;
        o_result.release_event = rel;
        o_result.repeat_event  = rep;
        o_result.phase         = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= kdar_pkg::PH_IDLE;
            r_countdown <= '0;
        end else if (i_valid) begin
            r_phase     <= n_phase;
            r_countdown <= n_countdown;
        end
    end

`ifndef SYNTHESIS
    a_release_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_result.release_event) |=> (r_phase == kdar_pkg::PH_IDLE))
        else $error("release event did not return to idle");

    a_repeat_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.repeat_event |-> (r_phase == kdar_pkg::PH_REPEAT))
        else $error("repeat event outside repeating phase");

    a_debounce_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && r_phase == kdar_pkg::PH_IDLE &&
         n_phase == kdar_pkg::PH_DEBOUNCE)
        |=> (r_countdown == kdar_pkg::DEBOUNCE_TICKS))
        else $error("debounce countdown not loaded");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |=> ($stable(r_phase) && $stable(r_countdown)))
        else $error("state moved without a transfer");
`endif

endmodule

### rtl/key_debounce_auto_repeat_unit.sv
// Debounced key with auto-repeat. Each input transfer is one poll of eight
// active-low key pins plus a tick flag (one 10 ms tick passed before the
// poll); each poll yields exactly one result transfer carrying a release
// event, a repeat event and the phase after the poll (0 idle, 1 debounce,
// 2 hold, 3 wait repeat, 4 repeating). A tick first lowers the block's own
// 16-bit countdown toward zero; a press debounces for 15 ticks, holds for
// 5, then waits repeat_delay ticks (0 means 150) and fires a repeat every
// repeat_period ticks (0 means 20). Release from hold or wait gives a
// release event; release while repeating returns to idle silently. A poll
// is taken every clock cycle unless the result channel stalls: the state
// update is one short pass of logic from the phase/countdown registers into
// the result register, which frees itself whenever its transfer completes,
// so throughput is one poll per cycle; a result shows in the cycle after
// its poll. The four registers sit on an APB-style port at byte addresses
// 0, 4, 8 and 12 and must only be written while no poll is in flight.
module key_debounce_auto_repeat_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // poll channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [kdar_pkg::PINS_W-1:0] i_key_pins,
    input  logic                        i_tick,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_release_event,
    output logic                        o_repeat_event,
    output logic [2:0]                  o_phase,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    kdar_pkg::t_cfg     r_cfg;
    kdar_pkg::t_result  core_res;
    kdar_pkg::t_result  r_res;
    logic               r_out_valid;
    logic               in_xfer;
    logic               cfg_wr;
    kdar_pkg::t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = kdar_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register write: one setup and one access phase, commit on access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_mask    <= kdar_pkg::RST_PRESS_MASK;
            r_cfg.other_mask    <= kdar_pkg::RST_OTHER_MASK;
            r_cfg.repeat_period <= kdar_pkg::RST_REPEAT_PERIOD;
            r_cfg.repeat_delay  <= kdar_pkg::RST_REPEAT_DELAY;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                kdar_pkg::REG_PRESS_MASK:    r_cfg.press_mask    <= pwdata[7:0];
                kdar_pkg::REG_OTHER_MASK:    r_cfg.other_mask    <= pwdata[7:0];
                kdar_pkg::REG_REPEAT_PERIOD: r_cfg.repeat_period <= pwdata[15:0];
                kdar_pkg::REG_REPEAT_DELAY:  r_cfg.repeat_delay  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back, zero-extended to the bus width
    always_comb begin
        unique case (reg_idx)
            kdar_pkg::REG_PRESS_MASK:    prdata = {24'd0, r_cfg.press_mask};
            kdar_pkg::REG_OTHER_MASK:    prdata = {24'd0, r_cfg.other_mask};
            kdar_pkg::REG_REPEAT_PERIOD: prdata = {16'd0, r_cfg.repeat_period};
            kdar_pkg::REG_REPEAT_DELAY:  prdata = {16'd0, r_cfg.repeat_delay};
            default:                     prdata = '0;
        endcase
    end

    // accept a poll whenever the result register is empty or emptying
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    kdar_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_xfer),
        .i_key_pins (i_key_pins),
        .i_tick     (i_tick),
        .i_cfg      (r_cfg),
        .o_result   (core_res)
    );

    // result register: load on every accepted poll, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_release_event = r_res.release_event;
    assign o_repeat_event  = r_res.repeat_event;
    assign o_phase         = r_res.phase;

endmodule

### test/tb_key_debounce_auto_repeat_unit.sv
`timescale 1ns / 1ps

module tb_key_debounce_auto_repeat_unit;

    // One poll as the sender offers it: pin levels plus the tick flag.
    typedef struct packed {
        logic [kdar_pkg::PINS_W-1:0] pins;
        logic                        tick;
    } t_key_poll;

    logic                        i_clk           = 1'b0;
    logic                        i_rst_n         = 1'b0;
    logic                        i_in_valid      = 1'b0;
    logic                        o_in_ready;
    logic [kdar_pkg::PINS_W-1:0] i_key_pins      = '0;
    logic                        i_tick          = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_ready     = 1'b0;
    logic                        o_release_event;
    logic                        o_repeat_event;
    logic [2:0]                  o_phase;
    logic                        psel            = 1'b0;
    logic                        penable         = 1'b0;
    logic                        pwrite          = 1'b0;
    logic [3:0]                  paddr           = '0;
    logic [31:0]                 pwdata          = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    key_debounce_auto_repeat_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_key_pins      (i_key_pins),
        .i_tick          (i_tick),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_release_event (o_release_event),
        .o_repeat_event  (o_repeat_event),
        .o_phase         (o_phase),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Register copies kept by the predictor; they follow every APB write.
    logic [kdar_pkg::PINS_W-1:0] cfg_press_mask    = kdar_pkg::RST_PRESS_MASK;
    logic [kdar_pkg::PINS_W-1:0] cfg_other_mask    = kdar_pkg::RST_OTHER_MASK;
    logic [kdar_pkg::CNT_W-1:0]  cfg_repeat_period = kdar_pkg::RST_REPEAT_PERIOD;
    logic [kdar_pkg::CNT_W-1:0]  cfg_repeat_delay  = kdar_pkg::RST_REPEAT_DELAY;

    // Predicted key state, advanced once per accepted poll.
    kdar_pkg::t_phase            model_phase = kdar_pkg::PH_IDLE;
    logic [kdar_pkg::CNT_W-1:0]  model_count = '0;

    t_key_poll         polls_pending[$];
    kdar_pkg::t_result key_results_due[$];

    t_key_poll         next_poll;
    kdar_pkg::t_result due;
    logic      poll_taken    = 1'b0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    logic      stall_request = 1'b0;
    logic      stall_served  = 1'b0;
    int        hold_left     = 0;
    int        mismatches    = 0;
    int        polls_checked = 0;
    int        releases_seen = 0;
    int        repeats_seen  = 0;
    logic [4:0] phases_seen  = '0;

    localparam int LONG_HOLD_OFF = 400;

    always #4 i_clk = ~i_clk;

    // Generous ceiling: the slowest legitimate run is well under a tenth of this.
    initial begin
        #(5_000_000);
        $display("simulation failed");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        if (mismatches < 40) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
        mismatches++;
    endtask

    // Advance the predicted key state by one poll and return the result it yields.
    function automatic kdar_pkg::t_result debounce_step(
        input logic [kdar_pkg::PINS_W-1:0] pins, input logic tick);
        logic [kdar_pkg::CNT_W-1:0] period_ticks;
        logic [kdar_pkg::CNT_W-1:0] delay_ticks;
        logic                       press;
        logic                       rel;
        logic                       rep;
        kdar_pkg::t_result          r;
        period_ticks = (cfg_repeat_period != '0) ? cfg_repeat_period
                                                 : kdar_pkg::DEFAULT_PERIOD;
        delay_ticks  = (cfg_repeat_delay != '0) ? cfg_repeat_delay
                                                : kdar_pkg::DEFAULT_DELAY;
        rel = 1'b0;
        rep = 1'b0;

        // The tick comes first and the countdown never wraps below zero.
        if (tick && model_count != '0) begin
            model_count = model_count - 1'b1;
        end

        if (cfg_other_mask != '0) begin
            press = ((pins & cfg_press_mask) == '0) && ((pins & cfg_other_mask) != '0);
            // All other-key pins low drops straight back to idle.
            if (model_phase != kdar_pkg::PH_IDLE && (pins & cfg_other_mask) == '0) begin
                model_phase = kdar_pkg::PH_IDLE;
            end
        end else begin
            press = (pins & cfg_press_mask) == '0;
        end

        if (press && model_phase == kdar_pkg::PH_IDLE) begin
            model_phase = kdar_pkg::PH_DEBOUNCE;
            model_count = kdar_pkg::DEBOUNCE_TICKS;
        end else if (model_phase != kdar_pkg::PH_IDLE) begin
            if (press && model_phase == kdar_pkg::PH_DEBOUNCE && model_count == '0) begin
                model_phase = kdar_pkg::PH_HOLD;
                model_count = kdar_pkg::HOLD_TICKS;
            end else if (!press && (model_phase == kdar_pkg::PH_HOLD ||
                                    model_phase == kdar_pkg::PH_WAIT)) begin
                rel         = 1'b1;
                model_phase = kdar_pkg::PH_IDLE;
            end else if (press && model_phase == kdar_pkg::PH_HOLD && model_count == '0) begin
                model_phase = kdar_pkg::PH_WAIT;
                model_count = delay_ticks;
            end else if (press && model_phase == kdar_pkg::PH_WAIT && model_count == '0) begin
                model_phase = kdar_pkg::PH_REPEAT;
            end else if (press && model_phase == kdar_pkg::PH_REPEAT &&
                         model_count == '0) begin
                model_count = period_ticks;
                rep         = 1'b1;
            end
        end
        // Releasing while repeating returns to idle without an event.
        if (model_phase >= kdar_pkg::PH_WAIT && !press) begin
            model_phase = kdar_pkg::PH_IDLE;
        end

        r.release_event = rel;
        r.repeat_event  = rep;
        r.phase         = model_phase;
        return r;
    endfunction

    function automatic void push_poll(input logic [kdar_pkg::PINS_W-1:0] pins,
                                      input logic tick);
        t_key_poll p;
        p.pins = pins;
        p.tick = tick;
        polls_pending.push_back(p);
    endfunction

    // Pin pattern that counts as a press under the current masks.
    function automatic logic [kdar_pkg::PINS_W-1:0] pick_pressed();
        logic [kdar_pkg::PINS_W-1:0] pins;
        logic [kdar_pkg::PINS_W-1:0] spare;
        int                          b;
        pins  = kdar_pkg::PINS_W'($urandom) & ~cfg_press_mask;
        spare = cfg_other_mask & ~cfg_press_mask;
        if (spare != '0 && (pins & cfg_other_mask) == '0) begin
            b = $urandom_range(0, kdar_pkg::PINS_W - 1);
            while (!spare[b]) b = (b + 1) % kdar_pkg::PINS_W;
            pins[b] = 1'b1;
        end
        return pins;
    endfunction

    // Pin pattern that ends a press: a press pin high, or every other-key pin low.
    function automatic logic [kdar_pkg::PINS_W-1:0] pick_released();
        logic [kdar_pkg::PINS_W-1:0] pins;
        int                          b;
        pins = kdar_pkg::PINS_W'($urandom);
        if (cfg_press_mask == '0 || (cfg_other_mask != '0 && $urandom_range(0, 3) == 0)) begin
            pins = pins & ~cfg_other_mask;
        end else if ((pins & cfg_press_mask) == '0) begin
            b = $urandom_range(0, kdar_pkg::PINS_W - 1);
            while (!cfg_press_mask[b]) b = (b + 1) % kdar_pkg::PINS_W;
            pins[b] = 1'b1;
        end
        return pins;
    endfunction

    // Queue one press of the given length followed by a short release; return polls queued.
    function automatic int queue_session(input int presses, input int tick_pct);
        int gap;
        gap = $urandom_range(1, 3);
        for (int i = 0; i < presses; i++) begin
            push_poll(pick_pressed(), $urandom_range(0, 99) < tick_pct);
        end
        for (int i = 0; i < gap; i++) begin
            push_poll(pick_released(), $urandom_range(0, 1));
        end
        return presses + gap;
    endfunction

    // Mix short presses, presses ending in hold or wait, and presses long enough to repeat.
    function automatic int session_length();
        int d;
        int p;
        d = (cfg_repeat_delay != '0) ? int'(cfg_repeat_delay) : int'(kdar_pkg::DEFAULT_DELAY);
        p = (cfg_repeat_period != '0) ? int'(cfg_repeat_period)
                                      : int'(kdar_pkg::DEFAULT_PERIOD);
        case ($urandom_range(0, 3))
            0: return $urandom_range(1, 18);
            1: return $urandom_range(19, 28);
            2: return ((22 + d + $urandom_range(0, 3 * p)) * 6) / 5;
            default: return $urandom_range(1, 60);
        endcase
    endfunction

    function automatic void fill_random(input int n_polls);
        int queued;
        queued = 0;
        while (queued < n_polls) begin
            if ($urandom_range(0, 99) < 20) begin
                push_poll(kdar_pkg::PINS_W'($urandom), $urandom_range(0, 1));
                queued++;
            end else begin
                queued += queue_session(session_length(), 85);
            end
        end
    endfunction

    // Hold until every queued poll has gone and every result has arrived, then let it settle.
    task automatic settle_block();
        while (polls_pending.size() != 0 || i_in_valid || key_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input kdar_pkg::t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            kdar_pkg::REG_PRESS_MASK:    cfg_press_mask    = value[kdar_pkg::PINS_W-1:0];
            kdar_pkg::REG_OTHER_MASK:    cfg_other_mask    = value[kdar_pkg::PINS_W-1:0];
            kdar_pkg::REG_REPEAT_PERIOD: cfg_repeat_period = value[kdar_pkg::CNT_W-1:0];
            kdar_pkg::REG_REPEAT_DELAY:  cfg_repeat_delay  = value[kdar_pkg::CNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input logic [kdar_pkg::PINS_W-1:0] press_m,
                                  input logic [kdar_pkg::PINS_W-1:0] other_m,
                                  input logic [kdar_pkg::CNT_W-1:0]  period,
                                  input logic [kdar_pkg::CNT_W-1:0]  delay);
        settle_block();
        apb_write(kdar_pkg::REG_PRESS_MASK, 32'(press_m));
        apb_write(kdar_pkg::REG_OTHER_MASK, 32'(other_m));
        apb_write(kdar_pkg::REG_REPEAT_PERIOD, 32'(period));
        apb_write(kdar_pkg::REG_REPEAT_DELAY, 32'(delay));
    endtask

    // Poll driver: offer the next pending poll, hold it until the transfer completes.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || poll_taken) begin
            if (polls_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_poll = polls_pending.pop_front();
                i_key_pins <= next_poll.pins;
                i_tick     <= next_poll.tick;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (stall_request && !stall_served) begin
            i_out_ready  <= 1'b0;
            hold_left    <= LONG_HOLD_OFF;
            stall_served <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on every poll transfer, check every result transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            poll_taken <= 1'b0;
        end else begin
            poll_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                key_results_due.push_back(debounce_step(i_key_pins, i_tick));
            end
            if (o_out_valid && i_out_ready) begin
                if (key_results_due.size() == 0) begin
                    flag_mismatch("result transfer with no poll outstanding");
                end else begin
                    due = key_results_due.pop_front();
                    if (o_release_event !== due.release_event) begin
                        flag_mismatch($sformatf("release_event got %b want %b",
                                                o_release_event, due.release_event));
                    end
                    if (o_repeat_event !== due.repeat_event) begin
                        flag_mismatch($sformatf("repeat_event got %b want %b",
                                                o_repeat_event, due.repeat_event));
                    end
                    if (o_phase !== 3'(due.phase)) begin
                        flag_mismatch($sformatf("phase got %0d want %0d", o_phase, due.phase));
                    end
                    polls_checked++;
                    if (due.release_event) releases_seen++;
                    if (due.repeat_event) repeats_seen++;
                    if (due.phase <= kdar_pkg::PH_REPEAT) phases_seen[due.phase] = 1'b1;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 15;
        recv_idle_pct = 73;

        // Directed polls under the reset register values (press pin 4, other pin 5).
        push_poll(8'hFF, 1'b0);            // nothing pressed
        push_poll(8'h00, 1'b1);            // press pins low but other pin low too: no press
        push_poll(8'hEF, 1'b0);            // press: enter debounce
        push_poll(8'hFF, 1'b1);            // release during debounce keeps debounce
        push_poll(8'hCF, 1'b0);            // other pin low forces idle
        push_poll(8'hEF, 1'b1);            // press again
        repeat (20) push_poll(8'hEF, 1'b1); // through debounce and hold into wait
        push_poll(8'hFF, 1'b0);            // release from wait: release event

        apply_settings(8'h03, 8'h0C, 16'd3, 16'd4);
        fill_random(220);
        // Sender pause: let everything drain before offering more.
        settle_block();
        fill_random(220);

        // Other-key check disabled, every pin a press pin, both defaults selected.
        apply_settings(8'hFF, 8'h00, 16'd0, 16'd0);
        send_idle_pct = 73;
        recv_idle_pct = 15;
        fill_random(400);

        // Empty press mask: any high pin is a press, all low forces idle.
        apply_settings(8'h00, 8'hFF, 16'd1, 16'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 1'b1;
        fill_random(350);

        // Full-width countdown: load a delay of 65535 and hold the press well inside it.
        apply_settings(8'h5A, 8'hA5, 16'hFFFF, 16'hFFFF);
        void'(queue_session(400, 100));

        settle_block();
        repeat (10) @(posedge i_clk);
        if (key_results_due.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", key_results_due.size()));
        end

        $display("checked %0d polls over five register settings: %0d release, %0d repeat events",
                 polls_checked, releases_seen, repeats_seen);
        $display("phases reached (idle..repeating as bits 0..4): %05b, mismatches: %0d",
                 phases_seen, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/kdar_pkg.sv
rtl/kdar_core.sv
rtl/key_debounce_auto_repeat_unit.sv
test/tb_key_debounce_auto_repeat_unit.sv
